// ===== hw/rtl/sps_pkg.sv =====
// Package for the H.264 SPS frame-size parser.
// Holds payload structs, syntax step codes and controller/datapath command types.
// No dependencies.
`default_nettype none
package sps_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] frame_width;
      logic [15:0] frame_height;
      logic [1:0]  parse_status;
   } rsp_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NOT_SPS  = 2'd1;
   localparam logic [1:0] STATUS_TRUNC    = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

   typedef enum logic [4:0] {
      ST_HDR, ST_PROFILE, ST_SKIP16, ST_SPSID, ST_CHROMA, ST_SEPCOL, ST_BDL, ST_BDC,
      ST_BYPASS, ST_SMPRESENT, ST_SLFLAG, ST_SLDELTA, ST_LOG2FN, ST_POCTYPE,
      ST_LOG2POC, ST_DPOAZ, ST_OFFNR, ST_OFFTB, ST_NCYCLE, ST_OFFREF, ST_NUMREF,
      ST_GAPS, ST_WMB, ST_HMU, ST_FMO, ST_MBAFF, ST_D8, ST_CROPF, ST_CROP, ST_HALT
   } step_type;

   typedef struct packed {
      logic       load;
      logic [7:0] data;
      logic       last;
      logic       shift;
      logic       restart;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic       last;
   } stat_type;

endpackage
`default_nettype wire

// ===== hw/rtl/sps_datapath.sv =====
// Datapath of the SPS parser: bit shifter, Exp-Golomb decoder, syntax walker,
// and the size computation. Depends on sps_pkg.
`default_nettype none
module sps_datapath #(
   parameter int MAX_REF_CYCLE = 255,
   parameter int SIZE_BITS     = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire sps_pkg::cmd_type cmd,
   output sps_pkg::stat_type     stat,
   output sps_pkg::rsp_type      result
);

   localparam int LIM_I = (SIZE_BITS >= 16) ? 65535 : ((1 << SIZE_BITS) - 1);
   localparam logic [17:0] LIM = 18'(LIM_I);

   logic [7:0]  byte_ff;
   logic        last_ff;
   sps_pkg::step_type step_ff, step_in;
   logic [1:0]  phase_ff, phase_in;
   logic [5:0]  zeros_ff, zeros_in;
   logic [31:0] acc_ff, acc_in;
   logic [5:0]  left_ff, left_in;
   logic [7:0]  prof_ff, prof_in;
   logic [1:0]  chroma_ff, chroma_in;
   logic        fonly_ff, fonly_in;
   logic [31:0] wmb_ff, wmb_in, hmu_ff, hmu_in;
   logic        cropp_ff, cropp_in;
   logic [31:0] crop_ff [4];
   logic [31:0] crop_in [4];
   logic [3:0]  sli_ff, sli_in;
   logic [6:0]  sci_ff, sci_in;
   logic [7:0]  lasts_ff, lasts_in;
   logic [9:0]  loop_ff, loop_in;
   logic        done_ff, done_in;
   logic [1:0]  err_ff, err_in;

   logic        bit_v;
   logic [31:0] sh;
   logic [31:0] v;
   logic        adv;
   logic [31:0] mag;
   logic [7:0]  ns;
   logic [3:0]  lcount;

   always_comb begin
      bit_v = byte_ff[7];
      step_in = step_ff; phase_in = phase_ff; zeros_in = zeros_ff; acc_in = acc_ff;
      left_in = left_ff; prof_in = prof_ff; chroma_in = chroma_ff; fonly_in = fonly_ff;
      wmb_in = wmb_ff; hmu_in = hmu_ff; cropp_in = cropp_ff;
      for (int i = 0; i < 4; i++) crop_in[i] = crop_ff[i];
      sli_in = sli_ff; sci_in = sci_ff; lasts_in = lasts_ff; loop_in = loop_ff;
      done_in = done_ff; err_in = err_ff;
      adv = 1'b0; v = '0;
      sh = {acc_ff[30:0], bit_v};
      mag = '0; ns = '0;
      lcount = (chroma_ff == 2'd3) ? 4'd12 : 4'd8;
      if (cmd.shift && step_ff != sps_pkg::ST_HALT) begin
         if (phase_ff == 2'd0) begin
            acc_in = sh; left_in = left_ff - 6'd1;
            if (left_ff == 6'd1) begin adv = 1'b1; v = sh; end
         end else if (phase_ff == 2'd1) begin
            if (!bit_v) begin
               if (zeros_ff >= 6'd31) begin
                  err_in = sps_pkg::STATUS_OVERFLOW; step_in = sps_pkg::ST_HALT;
               end else zeros_in = zeros_ff + 6'd1;
            end else if (zeros_ff == 6'd0) begin
               adv = 1'b1; v = '0;
            end else begin
               phase_in = 2'd2; left_in = zeros_ff; acc_in = '0;
            end
         end else begin
            acc_in = sh; left_in = left_ff - 6'd1;
            if (left_ff == 6'd1) begin
               adv = 1'b1;
               v = ((32'd1 << zeros_ff) - 32'd1) + sh;
            end
         end
      end
      if (adv) begin
         // Default: next field is a ue(v) of the following step.
         phase_in = 2'd1; zeros_in = '0; acc_in = '0;
         unique case (step_ff)
            sps_pkg::ST_HDR: begin
               if (v[4:0] != 5'd7) begin
                  err_in = sps_pkg::STATUS_NOT_SPS; step_in = sps_pkg::ST_HALT;
               end else begin
                  step_in = sps_pkg::ST_PROFILE; phase_in = 2'd0; left_in = 6'd8;
               end
            end
            sps_pkg::ST_PROFILE: begin
               prof_in = v[7:0];
               step_in = sps_pkg::ST_SKIP16; phase_in = 2'd0; left_in = 6'd16;
            end
            sps_pkg::ST_SKIP16: step_in = sps_pkg::ST_SPSID;
            sps_pkg::ST_SPSID:
               if (prof_ff == 8'd100 || prof_ff == 8'd110 || prof_ff == 8'd122 ||
                   prof_ff == 8'd144) step_in = sps_pkg::ST_CHROMA;
               else step_in = sps_pkg::ST_LOG2FN;
            sps_pkg::ST_CHROMA: begin
               if (v > 32'd3) begin
                  err_in = sps_pkg::STATUS_OVERFLOW; step_in = sps_pkg::ST_HALT;
               end else begin
                  chroma_in = v[1:0];
                  if (v == 32'd3) begin
                     step_in = sps_pkg::ST_SEPCOL; phase_in = 2'd0; left_in = 6'd1;
                  end else step_in = sps_pkg::ST_BDL;
               end
            end
            sps_pkg::ST_SEPCOL: step_in = sps_pkg::ST_BDL;
            sps_pkg::ST_BDL: step_in = sps_pkg::ST_BDC;
            sps_pkg::ST_BDC: begin
               step_in = sps_pkg::ST_BYPASS; phase_in = 2'd0; left_in = 6'd1;
            end
            sps_pkg::ST_BYPASS: begin
               step_in = sps_pkg::ST_SMPRESENT; phase_in = 2'd0; left_in = 6'd1;
            end
            sps_pkg::ST_SMPRESENT: begin
               sli_in = '0;
               if (v != 0) begin
                  step_in = sps_pkg::ST_SLFLAG; phase_in = 2'd0; left_in = 6'd1;
               end else step_in = sps_pkg::ST_LOG2FN;
            end
            sps_pkg::ST_SLFLAG: begin
               if (v != 0) begin
                  sci_in = '0; lasts_in = 8'd8; step_in = sps_pkg::ST_SLDELTA;
               end else begin
                  sli_in = sli_ff + 4'd1;
                  if (sli_in < lcount) begin
                     step_in = sps_pkg::ST_SLFLAG; phase_in = 2'd0; left_in = 6'd1;
                  end else step_in = sps_pkg::ST_LOG2FN;
               end
            end
            sps_pkg::ST_SLDELTA: begin
               mag = v[0] ? ({1'b0, v[31:1]} + 32'd1) : {1'b0, v[31:1]};
               ns = v[0] ? (lasts_ff + mag[7:0]) : (lasts_ff - mag[7:0]);
               sci_in = sci_ff + 7'd1;
               if (ns != 8'd0) lasts_in = ns;
               if (ns != 8'd0 && sci_in < ((sli_ff < 4'd6) ? 7'd16 : 7'd64)) begin
                  step_in = sps_pkg::ST_SLDELTA;
               end else begin
                  sli_in = sli_ff + 4'd1;
                  if (sli_in < lcount) begin
                     step_in = sps_pkg::ST_SLFLAG; phase_in = 2'd0; left_in = 6'd1;
                  end else step_in = sps_pkg::ST_LOG2FN;
               end
            end
            sps_pkg::ST_LOG2FN: step_in = sps_pkg::ST_POCTYPE;
            sps_pkg::ST_POCTYPE:
               if (v == 0) step_in = sps_pkg::ST_LOG2POC;
               else if (v == 1) begin
                  step_in = sps_pkg::ST_DPOAZ; phase_in = 2'd0; left_in = 6'd1;
               end else step_in = sps_pkg::ST_NUMREF;
            sps_pkg::ST_LOG2POC: step_in = sps_pkg::ST_NUMREF;
            sps_pkg::ST_DPOAZ: step_in = sps_pkg::ST_OFFNR;
            sps_pkg::ST_OFFNR: step_in = sps_pkg::ST_OFFTB;
            sps_pkg::ST_OFFTB: step_in = sps_pkg::ST_NCYCLE;
            sps_pkg::ST_NCYCLE: begin
               if (v > 32'(MAX_REF_CYCLE)) begin
                  err_in = sps_pkg::STATUS_OVERFLOW; step_in = sps_pkg::ST_HALT;
               end else begin
                  loop_in = v[9:0];
                  step_in = (v == 0) ? sps_pkg::ST_NUMREF : sps_pkg::ST_OFFREF;
               end
            end
            sps_pkg::ST_OFFREF: begin
               loop_in = loop_ff - 10'd1;
               step_in = (loop_in == 0) ? sps_pkg::ST_NUMREF : sps_pkg::ST_OFFREF;
            end
            sps_pkg::ST_NUMREF: begin
               step_in = sps_pkg::ST_GAPS; phase_in = 2'd0; left_in = 6'd1;
            end
            sps_pkg::ST_GAPS: step_in = sps_pkg::ST_WMB;
            sps_pkg::ST_WMB: begin wmb_in = v; step_in = sps_pkg::ST_HMU; end
            sps_pkg::ST_HMU: begin
               hmu_in = v; step_in = sps_pkg::ST_FMO; phase_in = 2'd0; left_in = 6'd1;
            end
            sps_pkg::ST_FMO: begin
               fonly_in = v[0]; phase_in = 2'd0; left_in = 6'd1;
               step_in = v[0] ? sps_pkg::ST_D8 : sps_pkg::ST_MBAFF;
            end
            sps_pkg::ST_MBAFF: begin
               step_in = sps_pkg::ST_D8; phase_in = 2'd0; left_in = 6'd1;
            end
            sps_pkg::ST_D8: begin
               step_in = sps_pkg::ST_CROPF; phase_in = 2'd0; left_in = 6'd1;
            end
            sps_pkg::ST_CROPF: begin
               cropp_in = v[0]; loop_in = '0;
               if (v[0]) step_in = sps_pkg::ST_CROP;
               else begin done_in = 1'b1; step_in = sps_pkg::ST_HALT; end
            end
            sps_pkg::ST_CROP: begin
               crop_in[loop_ff[1:0]] = v;
               loop_in = loop_ff + 10'd1;
               if (loop_in >= 10'd4) begin done_in = 1'b1; step_in = sps_pkg::ST_HALT; end
               else step_in = sps_pkg::ST_CROP;
            end
            default: begin done_in = 1'b1; step_in = sps_pkg::ST_HALT; end
         endcase
      end
   end

   // Result stage: pipelined size arithmetic over the finish sequence.
   logic [39:0] cx_ff, cy_ff;
   logic [39:0] rw_ff, rh_ff;
   logic [1:0]  ux, uyf;
   logic [1:0]  fy;
   logic [39:0] cx_in, cy_in, rw_in, rh_in;
   logic [39:0] wdiff, hdiff;
   logic [1:0]  st;
   logic [15:0] w, h;

   always_comb begin
      fy  = fonly_ff ? 2'd1 : 2'd2;
      ux  = (chroma_ff == 2'd1 || chroma_ff == 2'd2) ? 2'd2 : 2'd1;
      uyf = (chroma_ff == 2'd1) ? 2'd2 : 2'd1;
      cx_in = cropp_ff ? ((40'(crop_ff[0]) + 40'(crop_ff[1])) << (ux - 2'd1)) : '0;
      cy_in = cropp_ff ? ((40'(crop_ff[2]) + 40'(crop_ff[3])) << (uyf + fy - 2'd2)) : '0;
      rw_in = (40'(wmb_ff) + 40'd1) << 4;
      rh_in = ((40'(hmu_ff) + 40'd1) << (fy - 2'd1)) << 4;
      wdiff = rw_ff - cx_ff;
      hdiff = rh_ff - cy_ff;
      st = sps_pkg::STATUS_OK; w = '0; h = '0;
      if (err_ff != 2'd0) st = err_ff;
      else if (!done_ff) st = sps_pkg::STATUS_TRUNC;
      else begin
         if (cx_ff > rw_ff) st = sps_pkg::STATUS_OVERFLOW;
         else if (wdiff > 40'(LIM)) begin
            st = sps_pkg::STATUS_OVERFLOW; w = LIM[15:0];
         end else w = wdiff[15:0];
         if (cy_ff > rh_ff) st = sps_pkg::STATUS_OVERFLOW;
         else if (hdiff > 40'(LIM)) begin
            st = sps_pkg::STATUS_OVERFLOW; h = LIM[15:0];
         end else h = hdiff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin byte_ff <= cmd.data; end
      else if (cmd.shift) byte_ff <= {byte_ff[6:0], 1'b0};
      cx_ff <= cx_in; cy_ff <= cy_in; rw_ff <= rw_in; rh_ff <= rh_in;
      if (cmd.finish) result <= '{frame_width: w, frame_height: h, parse_status: st};
      if (reset || cmd.restart) begin
         last_ff <= 1'b0;
         step_ff <= sps_pkg::ST_HDR; phase_ff <= 2'd0; zeros_ff <= '0; acc_ff <= '0;
         left_ff <= 6'd8; prof_ff <= '0; chroma_ff <= 2'd1; fonly_ff <= 1'b1;
         wmb_ff <= '0; hmu_ff <= '0; cropp_ff <= 1'b0;
         for (int i = 0; i < 4; i++) crop_ff[i] <= '0;
         sli_ff <= '0; sci_ff <= '0; lasts_ff <= 8'd8; loop_ff <= '0;
         done_ff <= 1'b0; err_ff <= '0;
      end else begin
         if (cmd.load) last_ff <= cmd.last;
         step_ff <= step_in; phase_ff <= phase_in; zeros_ff <= zeros_in; acc_ff <= acc_in;
         left_ff <= left_in; prof_ff <= prof_in; chroma_ff <= chroma_in;
         fonly_ff <= fonly_in; wmb_ff <= wmb_in; hmu_ff <= hmu_in; cropp_ff <= cropp_in;
         for (int i = 0; i < 4; i++) crop_ff[i] <= crop_in[i];
         sli_ff <= sli_in; sci_ff <= sci_in; lasts_ff <= lasts_in; loop_ff <= loop_in;
         done_ff <= done_in; err_ff <= err_in;
      end
   end

   assign stat.last = last_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/sps_ctrl.sv =====
// Controller of the SPS parser: sequences eight bit shifts per byte,
// the size pipeline, and the result handshake. Depends on sps_pkg.
`default_nettype none
module sps_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire sps_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output sps_pkg::cmd_type       cmd,
   input  wire sps_pkg::stat_type stat
);

   typedef enum logic [2:0] {IDLE, SHIFT, CALC1, CALC2, CALC3, OUTPUT} state_type;

   state_type  state_ff;
   logic [2:0] cnt_ff;
   logic       acc;

   assign acc = req_valid && req_ready;

   always_comb begin
      req_ready = (state_ff == IDLE);
      cmd.load    = acc;
      cmd.data    = req_data.data_byte;
      cmd.last    = req_data.last_byte;
      cmd.shift   = (state_ff == SHIFT);
      cmd.finish  = (state_ff == CALC3);
      cmd.restart = (state_ff == OUTPUT) && rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE; cnt_ff <= '0; rsp_valid <= 1'b0;
      end else begin
         unique case (state_ff)
            IDLE: if (acc) begin
               state_ff <= SHIFT; cnt_ff <= '0;
            end
            SHIFT: begin
               cnt_ff <= cnt_ff + 3'd1;
               if (cnt_ff == 3'd7) state_ff <= stat.last ? CALC1 : IDLE;
            end
            CALC1: state_ff <= CALC2;
            CALC2: state_ff <= CALC3;
            CALC3: begin state_ff <= OUTPUT; rsp_valid <= 1'b1; end
            OUTPUT: if (rsp_ready) begin state_ff <= IDLE; rsp_valid <= 1'b0; end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/h264_sps_frame_size_parser_unit.sv =====
// Top level of the H.264 SPS frame-size parser.
// Depends on sps_pkg, sps_ctrl and sps_datapath.
//
//   channel | direction | payload
//   req     | in        | data_byte, last_byte
//   rsp     | out       | frame_width, frame_height, parse_status
//
// Each byte is accepted in IDLE and walked one bit per cycle in SHIFT, no new byte
// taken meanwhile; a last byte passes CALC1, CALC2, CALC3 (size math) to OUTPUT.
// Reset is synchronous; a held result stalls input until it is taken.
`default_nettype none
module h264_sps_frame_size_parser_unit #(
   parameter int MAX_REF_CYCLE = 255,
   parameter int SIZE_BITS     = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire sps_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sps_pkg::rsp_type      rsp_data
);

   sps_pkg::cmd_type  cmd;
   sps_pkg::stat_type stat;

   sps_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .cmd(cmd), .stat(stat)
   );

   sps_datapath #(.MAX_REF_CYCLE(MAX_REF_CYCLE), .SIZE_BITS(SIZE_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .result(rsp_data)
   );

   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input accepted while result pending");
   a_rsp_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid) else $error("result repeated");

endmodule
`default_nettype wire
